### hdl/vqdm_pkg.sv
// shared types, codes and helpers of the virtqueue descriptor manager
`default_nettype none

package vqdm_pkg;

  localparam int RING_SIZE = 64;
  localparam int IDX_W     = $clog2(RING_SIZE);
  localparam int LINK_W    = 8;
  localparam int CNT_W     = $clog2(RING_SIZE + 1);
  localparam int OP_W      = 3;
  localparam int ST_W      = 2;
  localparam int CTR_W     = 16;

  localparam logic [LINK_W-1:0] END_MARK = 8'hff;

  localparam logic [OP_W-1:0] OP_ALLOC = 3'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 3'd1;
  localparam logic [OP_W-1:0] OP_CHAIN = 3'd2;
  localparam logic [OP_W-1:0] OP_LINK  = 3'd3;
  localparam logic [OP_W-1:0] OP_POST  = 3'd4;
  localparam logic [OP_W-1:0] OP_POLL  = 3'd5;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [ST_W-1:0] ST_NOUSED = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [IDX_W-1:0]  desc_index;
    logic [IDX_W-1:0]  link_next;
    logic              link_has_next;
    logic [CTR_W-1:0]  device_used_index;
  } req_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [LINK_W-1:0] granted_desc;
    logic [IDX_W-1:0]  ring_slot;
    logic [CTR_W-1:0]  avail_index;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic alloc_rd;
    logic alloc_empty;
    logic alloc_wb;
    logic free_one;
    logic link_wr;
    logic post;
    logic poll;
    logic chain_init;
    logic chain_wb;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            head_ok;
    logic            chain_stop;
  } sts_t;

  function automatic logic [LINK_W-1:0] next_reset(input logic [IDX_W-1:0] idx);
    logic [LINK_W-1:0] val;
    if (idx == IDX_W'(RING_SIZE - 1)) begin
      val = END_MARK;
    end else begin
      val = LINK_W'(idx) + LINK_W'(1);
    end
    return val;
  endfunction

endpackage

`default_nettype wire

### hdl/vqdm_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module vqdm_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### hdl/vqdm_datapath.sv
// datapath: link and flag memories, free list head, ring counters, result word
`default_nettype none

module vqdm_datapath (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire vqdm_pkg::req_t req_i,
  input  wire vqdm_pkg::cmd_t cmd_i,
  output vqdm_pkg::sts_t     sts_o,
  output vqdm_pkg::rsp_t     rsp_o
);

  vqdm_pkg::req_t                      req_q;
  vqdm_pkg::rsp_t                      res_q;
  logic [vqdm_pkg::LINK_W-1:0]         head_q;
  logic [vqdm_pkg::CTR_W-1:0]          avail_q;
  logic [vqdm_pkg::CTR_W-1:0]          used_q;
  logic [vqdm_pkg::RING_SIZE-1:0]      next_vld_q;
  logic [vqdm_pkg::RING_SIZE-1:0]      flag_vld_q;
  logic [vqdm_pkg::IDX_W-1:0]          cur_q;
  logic [vqdm_pkg::CNT_W-1:0]          freed_q;
  logic                                rd_nvld_q;
  logic                                rd_fvld_q;
  logic [vqdm_pkg::IDX_W-1:0]          rd_addr_q;

  logic [vqdm_pkg::IDX_W-1:0]          raddr;
  logic [vqdm_pkg::IDX_W-1:0]          waddr;
  logic [vqdm_pkg::LINK_W-1:0]         wdata;
  logic                                we;
  logic [vqdm_pkg::LINK_W-1:0]         next_rdata;
  logic                                flag_rdata;
  logic [vqdm_pkg::LINK_W-1:0]         next_val;
  logic                                flag_val;

  assign raddr = cmd_i.alloc_rd ? head_q[vqdm_pkg::IDX_W-1:0] : cur_q;
  assign waddr = cmd_i.chain_wb ? cur_q : req_q.desc_index;
  assign wdata = cmd_i.link_wr ? vqdm_pkg::LINK_W'(req_q.link_next) : head_q;
  assign we    = cmd_i.free_one | cmd_i.chain_wb | cmd_i.link_wr;

  vqdm_ram #(
    .Width(vqdm_pkg::LINK_W),
    .Depth(vqdm_pkg::RING_SIZE)
  ) u_next_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(next_rdata)
  );

  vqdm_ram #(
    .Width(1),
    .Depth(vqdm_pkg::RING_SIZE)
  ) u_flag_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.link_wr),
    .waddr_i(req_q.desc_index),
    .wdata_i(req_q.link_has_next),
    .raddr_i(raddr),
    .rdata_o(flag_rdata)
  );

  // entries never written read as their reset contents
  assign next_val = rd_nvld_q ? next_rdata : vqdm_pkg::next_reset(rd_addr_q);
  assign flag_val = rd_fvld_q & flag_rdata;

  assign sts_o.op         = req_q.operation;
  assign sts_o.head_ok    = (head_q < vqdm_pkg::LINK_W'(vqdm_pkg::RING_SIZE));
  assign sts_o.chain_stop = !flag_val
                         || (next_val >= vqdm_pkg::LINK_W'(vqdm_pkg::RING_SIZE))
                         || (freed_q == vqdm_pkg::CNT_W'(vqdm_pkg::RING_SIZE - 1));
  assign rsp_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      avail_q    <= '0;
      used_q     <= '0;
      next_vld_q <= '0;
      flag_vld_q <= '0;
    end else begin
      if (we) begin
        next_vld_q[waddr] <= 1'b1;
      end
      if (cmd_i.link_wr) begin
        flag_vld_q[req_q.desc_index] <= 1'b1;
      end
      if (cmd_i.alloc_wb) begin
        head_q <= next_val;
      end else if (cmd_i.free_one) begin
        head_q <= vqdm_pkg::LINK_W'(req_q.desc_index);
      end else if (cmd_i.chain_wb) begin
        head_q <= vqdm_pkg::LINK_W'(cur_q);
      end
      if (cmd_i.post) begin
        avail_q <= avail_q + vqdm_pkg::CTR_W'(1);
      end
      if (cmd_i.poll && (req_q.device_used_index != used_q)) begin
        used_q <= used_q + vqdm_pkg::CTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_nvld_q <= next_vld_q[raddr];
    rd_fvld_q <= flag_vld_q[raddr];
    rd_addr_q <= raddr;
    if (cmd_i.capture) begin
      req_q <= req_i;
      res_q <= '0;
    end
    if (cmd_i.chain_init) begin
      cur_q   <= req_q.desc_index;
      freed_q <= '0;
    end else if (cmd_i.chain_wb) begin
      cur_q   <= next_val[vqdm_pkg::IDX_W-1:0];
      freed_q <= freed_q + vqdm_pkg::CNT_W'(1);
    end
    if (cmd_i.alloc_empty) begin
      res_q.status       <= vqdm_pkg::ST_EMPTY;
      res_q.granted_desc <= vqdm_pkg::END_MARK;
    end
    if (cmd_i.alloc_wb) begin
      res_q.granted_desc <= head_q;
    end
    if (cmd_i.post) begin
      res_q.ring_slot   <= avail_q[vqdm_pkg::IDX_W-1:0];
      res_q.avail_index <= avail_q + vqdm_pkg::CTR_W'(1);
    end
    if (cmd_i.poll) begin
      if (req_q.device_used_index == used_q) begin
        res_q.status <= vqdm_pkg::ST_NOUSED;
      end else begin
        res_q.ring_slot <= used_q[vqdm_pkg::IDX_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

### hdl/vqdm_ctrl.sv
// controller state machine sequencing each operation
`default_nettype none

module vqdm_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire vqdm_pkg::sts_t sts_i,
  output vqdm_pkg::cmd_t      cmd_o,
  output logic                busy_o,
  output logic                done_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_AL_WB = 5'b00100,
    S_CH_RD = 5'b01000,
    S_CH_WB = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        done_d  = 1'b1;
        case (sts_i.op)
          vqdm_pkg::OP_ALLOC: begin
            if (sts_i.head_ok) begin
              cmd_o.alloc_rd = 1'b1;
              state_d        = S_AL_WB;
              done_d         = 1'b0;
            end else begin
              cmd_o.alloc_empty = 1'b1;
            end
          end
          vqdm_pkg::OP_FREE: cmd_o.free_one = 1'b1;
          vqdm_pkg::OP_CHAIN: begin
            cmd_o.chain_init = 1'b1;
            state_d          = S_CH_RD;
            done_d           = 1'b0;
          end
          vqdm_pkg::OP_LINK: cmd_o.link_wr = 1'b1;
          vqdm_pkg::OP_POST: cmd_o.post = 1'b1;
          vqdm_pkg::OP_POLL: cmd_o.poll = 1'b1;
          default: ;
        endcase
      end
      S_AL_WB: begin
        cmd_o.alloc_wb = 1'b1;
        state_d        = S_IDLE;
        done_d         = 1'b1;
      end
      S_CH_RD: begin
        state_d = S_CH_WB;
      end
      S_CH_WB: begin
        cmd_o.chain_wb = 1'b1;
        if (sts_i.chain_stop) begin
          state_d = S_IDLE;
          done_d  = 1'b1;
        end else begin
          state_d = S_CH_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

endmodule

`default_nettype wire

### hdl/virtqueue_descriptor_manager_top.sv
// top level of the split virtqueue descriptor manager
//
// channel   handshake          word
// request   start / busy       req_i  (vqdm_pkg::req_t)
// result    done_o strobe      rsp_o  (vqdm_pkg::rsp_t)
//
// one word at a time: accept, execute state, registered strobe; allocate adds a write-back state
// free chain passes a read state and a write-back state per descriptor freed, one link memory read each
// reset is asynchronous; link entries carry valid bits, so no clearing pass
// the result is shown for one cycle and the next request can be taken in that cycle
// the receiver cannot stall, so the strobe is never held
`default_nettype none

module virtqueue_descriptor_manager_top (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire vqdm_pkg::req_t req_i,
  output logic                done_o,
  output vqdm_pkg::rsp_t      rsp_o
);

  vqdm_pkg::cmd_t cmd;
  vqdm_pkg::sts_t sts;

  vqdm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy),
    .done_o (done_o)
  );

  vqdm_datapath u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_i),
    .cmd_i (cmd),
    .sts_o (sts),
    .rsp_o (rsp_o)
  );

endmodule

`default_nettype wire

### hdl/vqdm_checker.sv
// port checker for the descriptor manager and its bind
`default_nettype none

module vqdm_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           start,
  input wire logic           busy,
  input wire logic           done_o,
  input wire vqdm_pkg::rsp_t rsp_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted request did not make the block busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe lasted more than one cycle");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result strobe without a request in progress");

  a_empty_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (rsp_o.status == vqdm_pkg::ST_EMPTY) |-> (rsp_o.granted_desc == vqdm_pkg::END_MARK))
    else $error("empty allocate did not report the end marker");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.status == vqdm_pkg::ST_OK) || (rsp_o.status == vqdm_pkg::ST_EMPTY)
               || (rsp_o.status == vqdm_pkg::ST_NOUSED))
    else $error("undefined status code");

endmodule

bind virtqueue_descriptor_manager_top vqdm_checker u_chk (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .start (start),
  .busy  (busy),
  .done_o(done_o),
  .rsp_o (rsp_o)
);

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 100ps
// testbench of the virtqueue descriptor manager: directed and random words checked against a predictor
module tb_top;
  import vqdm_pkg::*;

  localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;
  localparam int N_ITEMS     = 1600;
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;

  class desc_pool_scoreboard;
    logic [LINK_W-1:0] next_link [RING_SIZE];
    logic              has_next [RING_SIZE];
    logic [LINK_W-1:0] free_head;
    logic [CTR_W-1:0]  avail_count;
    logic [CTR_W-1:0]  last_used;
    rsp_t              last_rsp;
    rsp_t              expected_rsp_q [$];
    int                mismatches;

    function new();
      int i;
      for (i = 0; i < RING_SIZE; i++) begin
        next_link[i] = (i == RING_SIZE - 1) ? END_MARK : LINK_W'(i + 1);
        has_next[i]  = 1'b0;
      end
      free_head   = '0;
      avail_count = '0;
      last_used   = '0;
      last_rsp    = '0;
      mismatches  = 0;
    endfunction

    function void push_free(int d);
      next_link[d] = free_head;
      free_head    = LINK_W'(d);
    endfunction

    function int pending();
      return expected_rsp_q.size();
    endfunction

    function void note_request(req_t r);
      rsp_t e;
      int   cur;
      int   nxt;
      int   freed;
      bit   more;
      bit   walking;
      e = '0;
      case (r.operation)
        OP_ALLOC: begin
          if (free_head < RING_SIZE) begin
            e.granted_desc = free_head;
            free_head      = next_link[free_head];
          end else begin
            e.status       = ST_EMPTY;
            e.granted_desc = END_MARK;
          end
        end
        OP_FREE: begin
          push_free(r.desc_index);
        end
        OP_CHAIN: begin
          cur     = r.desc_index;
          freed   = 0;
          walking = 1'b1;
          while (walking) begin
            more = has_next[cur];
            nxt  = next_link[cur];
            push_free(cur);
            freed++;
            if (!more || nxt >= RING_SIZE || freed >= RING_SIZE) begin
              walking = 1'b0;
            end else begin
              cur = nxt;
            end
          end
        end
        OP_LINK: begin
          next_link[r.desc_index] = LINK_W'(r.link_next);
          has_next[r.desc_index]  = r.link_has_next;
        end
        OP_POST: begin
          e.ring_slot   = IDX_W'(avail_count % RING_SIZE);
          avail_count   = avail_count + 1'b1;
          e.avail_index = avail_count;
        end
        OP_POLL: begin
          if (r.device_used_index == last_used) begin
            e.status = ST_NOUSED;
          end else begin
            e.ring_slot = IDX_W'(last_used % RING_SIZE);
            last_used   = last_used + 1'b1;
          end
        end
        default: begin
        end
      endcase
      last_rsp = e;
      expected_rsp_q.push_back(e);
    endfunction

    function void check_response(rsp_t a);
      rsp_t e;
      if (expected_rsp_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected result word: status %0d grant %0d slot %0d avail %0d",
                   a.status, a.granted_desc, a.ring_slot, a.avail_index);
        end
        return;
      end
      e = expected_rsp_q.pop_front();
      if (a.status !== e.status || a.granted_desc !== e.granted_desc ||
          a.ring_slot !== e.ring_slot || a.avail_index !== e.avail_index) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("result mismatch: expected status %0d grant %0d slot %0d avail %0d",
                   e.status, e.granted_desc, e.ring_slot, e.avail_index);
          $display("                 got      status %0d grant %0d slot %0d avail %0d",
                   a.status, a.granted_desc, a.ring_slot, a.avail_index);
        end
      end
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  logic busy;
  req_t req_i  = '0;
  logic done_o;
  rsp_t rsp_o;

  desc_pool_scoreboard sb = new();
  int n_sent      = 0;
  int idle_cycles = 0;
  bit no_gaps     = 1'b0;

  virtqueue_descriptor_manager_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      sb.check_response(rsp_o);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int any_idx();
    return $urandom_range(0, RING_SIZE - 1);
  endfunction

  task automatic issue(input logic [OP_W-1:0] op, input int idx, input int nxt,
                       input bit flag, input int dev);
    req_t r;
    int   gap;
    r.operation         = op;
    r.desc_index        = IDX_W'(idx);
    r.link_next         = IDX_W'(nxt);
    r.link_has_next     = flag;
    r.device_used_index = CTR_W'(dev);
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_request(r);
    n_sent++;
  endtask

  task automatic chain_round();
    int k;
    int got;
    int i;
    int grants [8];
    k   = $urandom_range(1, 6);
    got = 0;
    for (i = 0; i < k; i++) begin
      issue(OP_ALLOC, any_idx(), any_idx(), $urandom_range(0, 1), $urandom);
      if (sb.last_rsp.status == ST_OK) begin
        grants[got] = sb.last_rsp.granted_desc;
        got++;
      end
    end
    if (got == 0) return;
    for (i = 0; i + 1 < got; i++) begin
      issue(OP_LINK, grants[i], grants[i + 1], 1'b1, $urandom);
    end
    issue(OP_LINK, grants[got - 1], any_idx(), ($urandom_range(0, 9) == 0), $urandom);
    for (i = 0; i < got; i++) begin
      issue(OP_POST, grants[i], any_idx(), $urandom_range(0, 1), $urandom);
    end
    issue(OP_POLL, any_idx(), any_idx(), $urandom_range(0, 1),
          sb.last_used + $urandom_range(0, 2));
    if ($urandom_range(0, 4) != 0) begin
      issue(OP_CHAIN, grants[0], any_idx(), $urandom_range(0, 1), $urandom);
    end else begin
      for (i = 0; i < got; i++) begin
        issue(OP_FREE, grants[i], any_idx(), $urandom_range(0, 1), $urandom);
      end
    end
  endtask

  task automatic post_poll_round();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) issue(OP_POST, any_idx(), any_idx(), $urandom_range(0, 1), $urandom);
    n = $urandom_range(1, 6);
    repeat (n) begin
      case ($urandom_range(0, 3))
        0: issue(OP_POLL, any_idx(), any_idx(), $urandom_range(0, 1), sb.last_used);
        1: issue(OP_POLL, any_idx(), any_idx(), $urandom_range(0, 1), $urandom);
        default: issue(OP_POLL, any_idx(), any_idx(), $urandom_range(0, 1),
                       sb.last_used + $urandom_range(1, 4));
      endcase
    end
  endtask

  task automatic noise_round();
    repeat ($urandom_range(1, 8)) begin
      issue(OP_W'($urandom_range(0, 7)), any_idx(), any_idx(), $urandom_range(0, 1),
            $urandom);
    end
  endtask

  // empty the free list, then rebuild it in index order
  task automatic drain_and_refill();
    int n;
    int tail;
    int i;
    n = 0;
    while (sb.free_head < RING_SIZE && n < 70) begin
      issue(OP_ALLOC, any_idx(), any_idx(), $urandom_range(0, 1), $urandom);
      n++;
    end
    repeat ($urandom_range(1, 2)) issue(OP_ALLOC, any_idx(), any_idx(), 1'b0, $urandom);
    // list left non-empty: splice the head onto an entry that still ends the list
    if (sb.free_head < RING_SIZE) begin
      tail = -1;
      for (i = 0; i < RING_SIZE; i++) begin
        if (sb.next_link[i] == END_MARK && i != sb.free_head) tail = i;
      end
      if (tail >= 0) begin
        issue(OP_LINK, sb.free_head, tail, 1'b0, $urandom);
        issue(OP_ALLOC, any_idx(), any_idx(), 1'b0, $urandom);
        issue(OP_ALLOC, any_idx(), any_idx(), 1'b0, $urandom);
      end
    end
    if (sb.free_head >= RING_SIZE) begin
      if ($urandom_range(0, 1)) begin
        issue(OP_LINK, RING_SIZE - 1, any_idx(), 1'b1, $urandom);
      end
      // chain walk that stops on the end marker
      issue(OP_FREE, RING_SIZE - 1, any_idx(), 1'b0, $urandom);
      issue(OP_ALLOC, any_idx(), any_idx(), 1'b0, $urandom);
      issue(OP_CHAIN, RING_SIZE - 1, any_idx(), 1'b0, $urandom);
      for (i = RING_SIZE - 2; i >= 0; i--) begin
        issue(OP_FREE, i, any_idx(), $urandom_range(0, 1), $urandom);
      end
    end
  endtask

  // two descriptors linked to each other, then a chain free that starts at the first of them
  task automatic cyclic_chain_round();
    int a;
    int b;
    a = any_idx();
    b = (a + $urandom_range(1, RING_SIZE - 1)) % RING_SIZE;
    issue(OP_LINK, a, b, 1'b1, $urandom);
    issue(OP_LINK, b, a, 1'b1, $urandom);
    issue(OP_CHAIN, a, any_idx(), 1'b0, $urandom);
    drain_and_refill();
  endtask

  initial begin
    int pick;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    issue(OP_POLL, 0, 0, 1'b0, 0);
    issue(OP_POST, 0, RING_SIZE - 1, 1'b1, 16'hffff);
    issue(OP_POST, RING_SIZE - 1, 0, 1'b0, 0);
    issue(OP_POLL, RING_SIZE - 1, RING_SIZE - 1, 1'b1, 16'hffff);
    issue(OP_POLL, 0, 0, 1'b0, 1);
    issue(OP_ALLOC, RING_SIZE - 1, RING_SIZE - 1, 1'b1, 16'hffff);
    issue(OP_ALLOC, 0, 0, 1'b0, 0);
    issue(OP_ALLOC, 0, 0, 1'b0, 0);
    issue(OP_LINK, 0, 1, 1'b1, 0);
    issue(OP_LINK, 1, 2, 1'b1, 0);
    issue(OP_LINK, 2, RING_SIZE - 1, 1'b0, 0);
    issue(OP_CHAIN, 0, 0, 1'b0, 0);
    issue(OP_ALLOC, 0, 0, 1'b0, 0);
    issue(OP_FREE, 2, RING_SIZE - 1, 1'b1, 16'hffff);
    issue(OP_RSVD6, RING_SIZE - 1, RING_SIZE - 1, 1'b1, 16'hffff);
    issue(OP_RSVD7, 0, 0, 1'b0, 0);
    cyclic_chain_round();

    while (n_sent < N_ITEMS) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      pick    = $urandom_range(0, 99);
      if (pick < 45) begin
        chain_round();
      end else if (pick < 70) begin
        post_poll_round();
      end else if (pick < 97) begin
        noise_round();
      end else if (pick < 99) begin
        drain_and_refill();
      end else begin
        cyclic_chain_round();
      end
    end
    start <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### virtqueue_descriptor_manager_top.f
hdl/vqdm_pkg.sv
hdl/vqdm_ram.sv
hdl/vqdm_datapath.sv
hdl/vqdm_ctrl.sv
hdl/virtqueue_descriptor_manager_top.sv
hdl/vqdm_checker.sv
tb/tb_top.sv
